// ----- sv/hfs_pkg.sv -----
// hfs_pkg: shared constants and types for the hole fit selector.
// No dependencies; imported by hfs_slot_table and hole_fit_selector.
`default_nettype none

package hfs_pkg;

  localparam int HOLE_SLOTS = 64;
  localparam int ADDR_BITS  = 16;
  localparam int IDX_W      = $clog2(HOLE_SLOTS);
  localparam int CFG_IDX_W  = 2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HOLE_SLOTS - 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_SIZE = CFG_IDX_W'(1);

  // fit modes
  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_BEST  = 2'd1;
  localparam logic [1:0] MODE_WORST = 2'd2;

  // request kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } hfs_state_t;

  // table write port
  typedef struct packed {
    logic                 en;
    logic [IDX_W-1:0]     idx;
    logic                 valid;
    logic [ADDR_BITS-1:0] base;
    logic [ADDR_BITS-1:0] size;
  } hfs_wr_t;

  // registered slot read data
  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] base;
    logic [ADDR_BITS-1:0] size;
  } hfs_slot_t;

endpackage

`default_nettype wire

// ----- sv/hfs_slot_table.sv -----
// hfs_slot_table: hole table, base/size memory plus per-slot valid flops.
// Depends on hfs_pkg.
`default_nettype none

module hfs_slot_table (
  input  wire                      clk,
  input  wire                      rst_n,
  input  hfs_pkg::hfs_wr_t         wr,
  input  wire                      rd_en,
  input  wire [hfs_pkg::IDX_W-1:0] rd_idx,
  output hfs_pkg::hfs_slot_t       rd_slot
);
  import hfs_pkg::*;

  logic [2*ADDR_BITS-1:0] mem [HOLE_SLOTS];
  logic [HOLE_SLOTS-1:0]  slot_valid_r;
  logic [2*ADDR_BITS-1:0] rd_data_r;
  logic                   rd_valid_r;

  // base/size store: no reset, only read where valid
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= {wr.base, wr.size};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      rd_valid_r   <= 1'b0;
    end else begin
      if (wr.en) begin
        slot_valid_r[wr.idx] <= wr.valid;
      end
      if (rd_en) begin
        rd_valid_r <= slot_valid_r[rd_idx];
      end
    end
  end

  assign rd_slot.valid = rd_valid_r;
  assign rd_slot.base  = rd_data_r[2*ADDR_BITS-1:ADDR_BITS];
  assign rd_slot.size  = rd_data_r[ADDR_BITS-1:0];

endmodule

`default_nettype wire

// ----- sv/hole_fit_selector.sv -----
// A table write is taken while idle and gives no result. A query reads every
// slot, one table read per slot through the single read port (ST_SCAN),
// judges the last slot in ST_DRAIN and hands the answer over in ST_DONE,
// which holds while an earlier result still waits on out_ready. Requests are
// taken only in ST_IDLE, so a new query waits for the answer; in_ready is low meanwhile.
// Reset (rst_n, synchronous, active low): slots invalid, first fit, size 65535.
`default_nettype none

module hole_fit_selector (
  input  wire                          clk,
  input  wire                          rst_n,
  // request channel
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          in_kind,
  input  wire [hfs_pkg::IDX_W-1:0]     in_entry_index,
  input  wire                          in_entry_valid,
  input  wire [hfs_pkg::ADDR_BITS-1:0] in_entry_base,
  input  wire [hfs_pkg::ADDR_BITS-1:0] in_entry_size,
  input  wire [hfs_pkg::ADDR_BITS-1:0] in_request_size,
  // result channel
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         out_found,
  output logic [hfs_pkg::IDX_W-1:0]    out_hole_index,
  output logic [hfs_pkg::ADDR_BITS-1:0] out_hole_base,
  output logic [hfs_pkg::ADDR_BITS-1:0] out_hole_size,
  // configuration write channel
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [hfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [hfs_pkg::ADDR_BITS-1:0] cfg_data
);
  import hfs_pkg::*;

  // ---------------------------------------------------------------- config
  logic [1:0]           fit_mode_r;
  logic [ADDR_BITS-1:0] mem_size_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r <= MODE_FIRST;
      mem_size_r <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FIT_MODE: fit_mode_r <= cfg_data[1:0];
        CFG_MEM_SIZE: mem_size_r <= cfg_data;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // ---------------------------------------------------------------- sequencer
  hfs_state_t state_r, state_nxt;

  logic                 in_acc;
  logic                 query_start;
  logic                 out_free;
  logic                 rd_en;
  logic                 load_out;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic                 eval_vld_r;   // table read data is for slot eval_idx_r
  logic [IDX_W-1:0]     eval_idx_r;
  logic [ADDR_BITS-1:0] req_r;
  logic [1:0]           mode_r;

  assign in_acc      = in_valid && in_ready;
  assign query_start = in_acc && (in_kind == KIND_QUERY);
  assign out_free    = !out_valid || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (query_start) state_nxt = ST_SCAN;
      ST_SCAN:  if (idx_r == LAST_IDX) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    load_out = 1'b0;
    idx_nxt  = idx_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        idx_nxt  = '0;
      end
      ST_SCAN: begin
        rd_en   = 1'b1;
        idx_nxt = idx_r + 1'b1;
      end
      ST_DRAIN: ;
      ST_DONE:  load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      idx_r      <= '0;
      eval_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      eval_vld_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    eval_idx_r <= idx_r;
    if (query_start) begin
      req_r  <= in_request_size;
      mode_r <= fit_mode_r;
    end
  end

  // ---------------------------------------------------------------- table
  hfs_wr_t   wr;
  hfs_slot_t slot;

  assign wr.en    = in_acc && (in_kind == KIND_WRITE);
  assign wr.idx   = in_entry_index;
  assign wr.valid = in_entry_valid;
  assign wr.base  = in_entry_base;
  assign wr.size  = in_entry_size;

  hfs_slot_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_idx  (idx_r),
    .rd_slot (slot)
  );

  // ---------------------------------------------------------------- compare unit
  // One slot judged per cycle. bound_r is the best-fit upper bound or the
  // worst-fit running maximum; first fit only takes while nothing is held.
  logic                 pick_found_r;
  logic [IDX_W-1:0]     pick_idx_r;
  logic [ADDR_BITS-1:0] pick_base_r;
  logic [ADDR_BITS-1:0] bound_r;
  logic [ADDR_BITS-1:0] pick_size_r;
  logic                 fits;
  logic                 take;

  assign fits = eval_vld_r && slot.valid && (slot.size >= req_r);

  always_comb begin
    case (mode_r)
      MODE_FIRST: take = fits && !pick_found_r;
      MODE_BEST:  take = fits && (slot.size <= bound_r);  // tie: later slot wins
      MODE_WORST: take = fits && (slot.size > bound_r);   // tie: earlier slot kept
      default:    take = 1'b0;                            // unknown mode: never
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pick_found_r <= 1'b0;
    end else if (query_start) begin
      pick_found_r <= 1'b0;
    end else if (take) begin
      pick_found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (query_start) begin
      pick_idx_r  <= '0;
      pick_base_r <= '0;
      pick_size_r <= '0;
      bound_r     <= (fit_mode_r == MODE_BEST) ? mem_size_r : '0;
    end else if (take) begin
      pick_idx_r  <= eval_idx_r;
      pick_base_r <= slot.base;
      pick_size_r <= slot.size;
      bound_r     <= slot.size;
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_found      <= pick_found_r;
      out_hole_index <= pick_idx_r;
      out_hole_base  <= pick_base_r;
      out_hole_size  <= pick_size_r;
    end
  end

  // ---------------------------------------------------------------- checks
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_DRAIN) |-> !in_ready)
    else $error("request taken during a scan");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the hand-over state");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |->
      (out_hole_index == '0 && out_hole_base == '0 && out_hole_size == '0))
    else $error("not-found result carries slot data");

  a_take_only_scanning: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> (state_r == ST_SCAN || state_r == ST_DRAIN))
    else $error("compare unit took a slot while idle");

endmodule

`default_nettype wire
